>>> design/cop_pkg.sv
package cop_pkg;

   // Store sizes and fixed-point format defaults. Store depths are powers of two,
   // so address wrap is a plain truncation.
   localparam int ACT_DEPTH_DEF    = 8192;
   localparam int WEIGHT_DEPTH_DEF = 32768;
   localparam int MAX_CHANNELS_DEF = 64;
   localparam int FRAC_BITS_DEF    = 8;

   localparam int DATA_W     = 16;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_ADDR_W = 4;

   // Working widths of the tap sequencer and accumulator
   localparam int POS_W        = 11;  // signed input row/column, covers 63*7+6
   localparam int ACT_CALC_W   = 24;  // signed activation address before wrap
   localparam int WGT_CALC_W   = 20;  // weight address before wrap
   localparam int ACC_W        = 48;  // exact sum of all products plus bias
   localparam int DRAIN_CYCLES = 2;   // read data stage plus product stage
   localparam int DRAIN_CNT_W  = 2;

   // Request type codes
   localparam logic [1:0] REQ_LOAD_ACT  = 2'd0;
   localparam logic [1:0] REQ_LOAD_WGT  = 2'd1;
   localparam logic [1:0] REQ_LOAD_BIAS = 2'd2;
   localparam logic [1:0] REQ_COMPUTE   = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_IN_WIDTH     = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IN_HEIGHT    = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_IN_CHANNELS  = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_CHANNELS = 4'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_SIZE  = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRIDE_W     = 4'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRIDE_H     = 4'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD          = 4'd7;

   typedef struct packed {
      logic [6:0] in_width;
      logic [6:0] in_height;
      logic [6:0] in_channels;
      logic [6:0] out_channels;
      logic [2:0] kernel_size;
      logic [2:0] stride_w;
      logic [2:0] stride_h;
      logic [1:0] pad;
   } cop_cfg_type;

   localparam cop_cfg_type CFG_RESET = '{
      in_width:     7'd32,
      in_height:    7'd32,
      in_channels:  7'd3,
      out_channels: 7'd32,
      kernel_size:  3'd3,
      stride_w:     3'd1,
      stride_h:     3'd1,
      pad:          2'd1
   };

   typedef struct packed {
      logic [1:0]         req_type;
      logic [14:0]        index;
      logic signed [15:0] value;
      logic [5:0]         out_channel;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
   } cop_req_type;

   typedef struct packed {
      logic signed [15:0] conv_value;
      logic               bad_position;
   } cop_rsp_type;

   typedef struct packed {
      logic [5:0] out_channel;
      logic [5:0] out_row;
      logic [5:0] out_col;
   } cop_point_type;

   // One tap read issued by the sequencer
   typedef struct packed {
      logic                         issue;
      logic                         in_bounds;
      logic signed [ACT_CALC_W-1:0] act_addr;
      logic [WGT_CALC_W-1:0]        wgt_addr;
   } cop_tap_type;

   // Sequencer status toward the top level
   typedef struct packed {
      logic busy;
      logic done;
      logic bad;
   } cop_seq_status_type;

endpackage

>>> design/cop_ram.sv
module cop_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/cop_tapgen.sv
module cop_tapgen (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  cop_pkg::cop_point_type       point,
   input  cop_pkg::cop_cfg_type         cfg,
   input  logic                         out_free,
   output cop_pkg::cop_tap_type         tap,
   output cop_pkg::cop_seq_status_type  status
);

   localparam int POS_W       = cop_pkg::POS_W;
   localparam int ACT_CALC_W  = cop_pkg::ACT_CALC_W;
   localparam int WGT_CALC_W  = cop_pkg::WGT_CALC_W;
   localparam int DRAIN_CNT_W = cop_pkg::DRAIN_CNT_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PREP  = 6'b000010,
      ST_BASE  = 6'b000100,
      ST_RUN   = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FIN   = 6'b100000
   } cop_state_type;

   cop_state_type state_ff, state_in;

   cop_pkg::cop_point_type point_ff, point_in;

   // Setup products
   logic [5:0]            kk_ff, kk_in;
   logic [12:0]           ocic_ff, ocic_in;
   logic [13:0]           plane_ff, plane_in;
   logic signed [POS_W-1:0] ih0_ff, ih0_in;
   logic signed [POS_W-1:0] iw0_ff, iw0_in;
   logic                  bad_ff, bad_in;

   // Walk state
   logic [6:0]              ic_ff, ic_in;
   logic [2:0]              kh_ff, kh_in;
   logic [2:0]              kw_ff, kw_in;
   logic signed [POS_W-1:0] ih_ff, ih_in;
   logic signed [POS_W-1:0] iw_ff, iw_in;
   logic signed [ACT_CALC_W-1:0] act_row_ff, act_row_in;
   logic signed [ACT_CALC_W-1:0] ch_row0_ff, ch_row0_in;
   logic [WGT_CALC_W-1:0]   wgt_ff, wgt_in;
   logic [DRAIN_CNT_W-1:0]  drain_ff, drain_in;

   // Effective strides and window checks
   logic [2:0]  sw_eff, sh_eff;
   logic [8:0]  oh_s, ow_s;
   logic [9:0]  need_h, need_w;
   logic [9:0]  span_h, span_w;
   logic [18:0] wgt_base;
   logic signed [18:0] row0;
   logic        tap_in_bounds;
   logic        last_kw, last_kh, last_ic;

   always_comb begin
      sw_eff = (point_ff.out_col == 6'd0 && cfg.stride_w == 3'd0) ? 3'd1 :
               ((cfg.stride_w == 3'd0) ? 3'd1 : cfg.stride_w);
      sh_eff = (cfg.stride_h == 3'd0) ? 3'd1 : cfg.stride_h;
      oh_s   = 9'(point_ff.out_row * sh_eff);
      ow_s   = 9'(point_ff.out_col * sw_eff);
      need_h = 10'(oh_s) + 10'(cfg.kernel_size);
      need_w = 10'(ow_s) + 10'(cfg.kernel_size);
      span_h = 10'(cfg.in_height) + 10'({cfg.pad, 1'b0});
      span_w = 10'(cfg.in_width) + 10'({cfg.pad, 1'b0});
      wgt_base = 19'(ocic_ff * kk_ff);
      row0     = 19'(ih0_ff * $signed({1'b0, cfg.in_width}));
   end

   assign tap_in_bounds = (ih_ff >= 0) && (ih_ff < $signed(POS_W'(cfg.in_height))) &&
                          (iw_ff >= 0) && (iw_ff < $signed(POS_W'(cfg.in_width)));
   assign last_kw = (kw_ff == cfg.kernel_size - 3'd1);
   assign last_kh = (kh_ff == cfg.kernel_size - 3'd1);
   assign last_ic = (ic_ff == cfg.in_channels - 7'd1);

   // Next-state and walk logic
   always_comb begin
      state_in   = state_ff;
      point_in   = point_ff;
      kk_in      = kk_ff;
      ocic_in    = ocic_ff;
      plane_in   = plane_ff;
      ih0_in     = ih0_ff;
      iw0_in     = iw0_ff;
      bad_in     = bad_ff;
      ic_in      = ic_ff;
      kh_in      = kh_ff;
      kw_in      = kw_ff;
      ih_in      = ih_ff;
      iw_in      = iw_ff;
      act_row_in = act_row_ff;
      ch_row0_in = ch_row0_ff;
      wgt_in     = wgt_ff;
      drain_in   = drain_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               point_in = point;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            kk_in    = 6'(cfg.kernel_size * cfg.kernel_size);
            ocic_in  = 13'(point_ff.out_channel * cfg.in_channels);
            plane_in = 14'(cfg.in_height * cfg.in_width);
            ih0_in   = $signed(POS_W'(oh_s)) - $signed(POS_W'(cfg.pad));
            iw0_in   = $signed(POS_W'(ow_s)) - $signed(POS_W'(cfg.pad));
            bad_in   = (7'(point_ff.out_channel) >= cfg.out_channels) ||
                       (need_h > span_h) || (need_w > span_w);
            state_in = ST_BASE;
         end
         ST_BASE: begin
            ic_in      = '0;
            kh_in      = '0;
            kw_in      = '0;
            ih_in      = ih0_ff;
            iw_in      = iw0_ff;
            act_row_in = ACT_CALC_W'(row0);
            ch_row0_in = ACT_CALC_W'(row0);
            wgt_in     = WGT_CALC_W'(wgt_base);
            drain_in   = '0;
            if (bad_ff) begin
               state_in = ST_FIN;
            end else if (cfg.kernel_size == 3'd0 || cfg.in_channels == 7'd0) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // Advance one tap: column, then row, then channel
            wgt_in = wgt_ff + WGT_CALC_W'(1);
            if (!last_kw) begin
               kw_in = kw_ff + 3'd1;
               iw_in = iw_ff + POS_W'(1);
            end else begin
               kw_in = '0;
               iw_in = iw0_ff;
               if (!last_kh) begin
                  kh_in      = kh_ff + 3'd1;
                  ih_in      = ih_ff + POS_W'(1);
                  act_row_in = act_row_ff + ACT_CALC_W'(cfg.in_width);
               end else begin
                  kh_in      = '0;
                  ih_in      = ih0_ff;
                  ch_row0_in = ch_row0_ff + ACT_CALC_W'(plane_ff);
                  act_row_in = ch_row0_ff + ACT_CALC_W'(plane_ff);
                  ic_in      = ic_ff + 7'd1;
                  if (last_ic) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_CNT_W'(1);
            if (drain_ff == DRAIN_CNT_W'(cop_pkg::DRAIN_CYCLES - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff   <= point_in;
      kk_ff      <= kk_in;
      ocic_ff    <= ocic_in;
      plane_ff   <= plane_in;
      ih0_ff     <= ih0_in;
      iw0_ff     <= iw0_in;
      bad_ff     <= bad_in;
      ic_ff      <= ic_in;
      kh_ff      <= kh_in;
      kw_ff      <= kw_in;
      ih_ff      <= ih_in;
      iw_ff      <= iw_in;
      act_row_ff <= act_row_in;
      ch_row0_ff <= ch_row0_in;
      wgt_ff     <= wgt_in;
      drain_ff   <= drain_in;
   end

   // Tap read toward the stores
   assign tap.issue     = (state_ff == ST_RUN);
   assign tap.in_bounds = tap_in_bounds;
   assign tap.act_addr  = act_row_ff + ACT_CALC_W'(iw_ff);
   assign tap.wgt_addr  = wgt_ff;

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_FIN);
   assign status.bad  = bad_ff;

endmodule

>>> design/cop_mac.sv
module cop_mac #(
   parameter int FRAC_BITS = cop_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               tap_use,
   input  logic signed [15:0] act_data,
   input  logic signed [15:0] wgt_data,
   input  logic signed [15:0] bias,
   output logic signed [15:0] result
);

   localparam int ACC_W = cop_pkg::ACC_W;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'((64'd1 << FRAC_BITS) >> 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'(32'sd32767);
   localparam logic signed [ACC_W-1:0] SAT_MIN    = ACC_W'(-32'sd32768);

   logic                    data_vld_ff;
   logic                    prod_vld_ff;
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] bias_term;
   logic signed [ACC_W-1:0] sum;
   logic signed [ACC_W-1:0] rounded;

   // Track read data through the product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         data_vld_ff <= tap_use;
         prod_vld_ff <= data_vld_ff;
      end
   end

   assign prod_in = act_data * wgt_data;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Accumulate exact Q16.16 products
   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Add scaled bias, round half up, saturate to Q8.8
   always_comb begin
      bias_term = ACC_W'(bias) <<< FRAC_BITS;
      sum       = acc_ff + bias_term + ROUND_HALF;
      rounded   = sum >>> FRAC_BITS;
      if (rounded > SAT_MAX) begin
         result = 16'sd32767;
      end else if (rounded < SAT_MIN) begin
         result = -16'sd32768;
      end else begin
         result = rounded[15:0];
      end
   end

endmodule

>>> design/conv2d_output_point.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    cop_req_type: loads and compute requests
// rsp      out        rsp_valid/stall    cop_rsp_type: one result per compute request
// csr      in         csr_we             csr_addr, csr_wdata: layer registers
//
// A load request writes its store at the accepting edge. A compute request
// reads in_channels * kernel_size^2 taps, one tap read per cycle from the
// activation and weight memories, through setup, run, drain and finish states;
// an out-of-range point skips the tap reads and the drain.
// Reset clears the registers to their defaults and all bias valid bits to zero.
// req_stall stays high while a compute request is in flight; a result waiting
// on rsp_stall holds the block at the end of the next compute only.
module conv2d_output_point #(
   parameter int ACT_DEPTH    = cop_pkg::ACT_DEPTH_DEF,
   parameter int WEIGHT_DEPTH = cop_pkg::WEIGHT_DEPTH_DEF,
   parameter int MAX_CHANNELS = cop_pkg::MAX_CHANNELS_DEF,
   parameter int FRAC_BITS    = cop_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cop_pkg::cop_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cop_pkg::cop_rsp_type                rsp_data,
   input  logic                                csr_we,
   input  logic [cop_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [cop_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ACT_AW  = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
   localparam int WGT_AW  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int BIAS_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DATA_W  = cop_pkg::DATA_W;

   cop_pkg::cop_cfg_type cfg_ff, cfg_in;

   logic req_take;
   logic load_act, load_wgt, load_bias, compute_start;
   logic out_free;

   cop_pkg::cop_point_type        point;
   cop_pkg::cop_tap_type          tap;
   cop_pkg::cop_seq_status_type   status;

   logic [DATA_W-1:0]        act_rdata, wgt_rdata, bias_rdata;
   logic [MAX_CHANNELS-1:0]  bias_vld_ff, bias_vld_in;
   logic                     bias_hit_ff;
   logic [BIAS_AW-1:0]       bias_waddr, bias_raddr;
   logic signed [DATA_W-1:0] bias_val;
   logic signed [DATA_W-1:0] mac_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   cop_pkg::cop_rsp_type rsp_data_ff, rsp_data_in;

   // Decode accepted requests
   assign req_stall     = status.busy;
   assign req_take      = req_valid && !req_stall;
   assign load_act      = req_take && (req_data.req_type == cop_pkg::REQ_LOAD_ACT);
   assign load_wgt      = req_take && (req_data.req_type == cop_pkg::REQ_LOAD_WGT);
   assign load_bias     = req_take && (req_data.req_type == cop_pkg::REQ_LOAD_BIAS);
   assign compute_start = req_take && (req_data.req_type == cop_pkg::REQ_COMPUTE);

   assign point.out_channel = req_data.out_channel;
   assign point.out_row     = req_data.out_row;
   assign point.out_col     = req_data.out_col;

   // Register file writes, truncated to each field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            cop_pkg::CSR_IN_WIDTH:     cfg_in.in_width     = csr_wdata;
            cop_pkg::CSR_IN_HEIGHT:    cfg_in.in_height    = csr_wdata;
            cop_pkg::CSR_IN_CHANNELS:  cfg_in.in_channels  = csr_wdata;
            cop_pkg::CSR_OUT_CHANNELS: cfg_in.out_channels = csr_wdata;
            cop_pkg::CSR_KERNEL_SIZE:  cfg_in.kernel_size  = csr_wdata[2:0];
            cop_pkg::CSR_STRIDE_W:     cfg_in.stride_w     = csr_wdata[2:0];
            cop_pkg::CSR_STRIDE_H:     cfg_in.stride_h     = csr_wdata[2:0];
            cop_pkg::CSR_PAD:          cfg_in.pad          = csr_wdata[1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cop_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Tap sequencer
   cop_tapgen u_tapgen (
      .clock    (clock),
      .reset    (reset),
      .start    (compute_start),
      .point    (point),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .tap      (tap),
      .status   (status)
   );

   // Activation and weight stores: written by loads, read by taps
   cop_ram #(.WIDTH(DATA_W), .DEPTH(ACT_DEPTH)) u_act_ram (
      .clock (clock),
      .we    (load_act),
      .waddr (ACT_AW'(req_data.index)),
      .wdata (req_data.value),
      .re    (tap.issue),
      .raddr (tap.act_addr[ACT_AW-1:0]),
      .rdata (act_rdata)
   );

   cop_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_wgt_ram (
      .clock (clock),
      .we    (load_wgt),
      .waddr (WGT_AW'(req_data.index)),
      .wdata (req_data.value),
      .re    (tap.issue),
      .raddr (tap.wgt_addr[WGT_AW-1:0]),
      .rdata (wgt_rdata)
   );

   // Bias store with per-entry valid bits; an unwritten entry reads as zero
   assign bias_waddr = BIAS_AW'(req_data.index);
   assign bias_raddr = BIAS_AW'(req_data.out_channel);

   cop_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_bias_ram (
      .clock (clock),
      .we    (load_bias),
      .waddr (bias_waddr),
      .wdata (req_data.value),
      .re    (compute_start),
      .raddr (bias_raddr),
      .rdata (bias_rdata)
   );

   always_comb begin
      bias_vld_in = bias_vld_ff;
      if (load_bias) begin
         bias_vld_in[bias_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_vld_ff <= '0;
         bias_hit_ff <= 1'b0;
      end else begin
         bias_vld_ff <= bias_vld_in;
         if (compute_start) begin
            bias_hit_ff <= bias_vld_ff[bias_raddr];
         end
      end
   end

   assign bias_val = bias_hit_ff ? $signed(bias_rdata) : '0;

   // Multiply-accumulate and output rounding
   cop_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (compute_start),
      .tap_use  (tap.issue && tap.in_bounds),
      .act_data ($signed(act_rdata)),
      .wgt_data ($signed(wgt_rdata)),
      .bias     (bias_val),
      .result   (mac_result)
   );

   // Output register: load on a finished compute, drop when taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.done && out_free) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.bad_position = status.bad;
         rsp_data_in.conv_value   = status.bad ? '0 : mac_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A flagged point always carries a zero value
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_position |-> rsp_data.conv_value == '0)
      else $error("flagged result with nonzero value");

   // A compute request locks out further requests on the next cycle
   a_compute_lock: assert property (@(posedge clock) disable iff (reset)
      compute_start |=> req_stall)
      else $error("request accepted right after a compute start");

   // No store is loaded while taps are being read
   a_tap_interlock: assert property (@(posedge clock) disable iff (reset)
      tap.issue |-> req_stall && !load_act && !load_wgt && !load_bias)
      else $error("store write during tap reads");

endmodule
